/* rtl/bezier_triangle_eval_macros.svh */
// Assertion helpers
`ifndef BEZIER_TRIANGLE_EVAL_MACROS_SVH
`define BEZIER_TRIANGLE_EVAL_MACROS_SVH
`define BTE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BTE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* rtl/bte_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package bte_pkg;
    localparam int MAX_DEGREE_DEF = 8;
    localparam int NET_DEPTH = 45;
    localparam int PT_W = 96;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_BLEND,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic        start;
        logic [15:0] w;
        logic [31:0] a;
        logic        clr;
    } t_mac_ctl;
endpackage
`default_nettype wire

/* rtl/bte_mac.sv */
`timescale 1ns / 1ps
`default_nettype none
// one weighted product per cycle while start is set, accumulates and rounds/saturates
// clr with start begins a new sum with the current product
module bte_mac (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire bte_pkg::t_mac_ctl i_ctl,
    output logic [31:0]           o_res
);
    import bte_pkg::*;
    logic signed [49:0] r_acc, n_acc;
    logic signed [48:0] w_prod;
    logic signed [50:0] w_rnd;
    logic signed [35:0] w_q;

    assign w_prod = $signed({1'b0, i_ctl.w}) * $signed(i_ctl.a);

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clr && i_ctl.start) begin
            n_acc = 50'(w_prod);
        end else if (i_ctl.clr) begin
            n_acc = '0;
        end else if (i_ctl.start) begin
            n_acc = r_acc + 50'(w_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    assign w_rnd = 51'(r_acc) + 51'sd16384;
    assign w_q   = w_rnd[50:15];

    always_comb begin
        if (w_q > 36'sd2147483647) begin
            o_res = 32'h7fffffff;
        end else if (w_q < -36'sd2147483648) begin
            o_res = 32'h80000000;
        end else begin
            o_res = w_q[31:0];
        end
    end
endmodule
`default_nettype wire

/* rtl/bezier_triangle_eval.sv */
`timescale 1ns / 1ps
`default_nettype none
// Triangular Bezier patch evaluator (de Casteljau). A load transaction (mode 0)
// writes one Q16.16 point into the control net and gives no result.
// An evaluate transaction (mode 1) copies the (n+1)(n+2)/2 points of the net,
// then computes each blended point with one shared 32x16 multiplier: three
// memory reads, one multiply-accumulate per weight and coordinate, then the
// finish of the last coordinate and the write-back of the point. The shared
// multiplier and the one read port of the work memory bound the evaluation rate.
// The result is held on the output until taken; no new transaction is taken
// meanwhile.
module bezier_triangle_eval (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_mode,
    input  wire logic [5:0]  i_point_index,
    input  wire logic signed [31:0] i_coord_x,
    input  wire logic signed [31:0] i_coord_y,
    input  wire logic signed [31:0] i_coord_z,
    input  wire logic [15:0] i_weight_r,
    input  wire logic [15:0] i_weight_s,
    input  wire logic [15:0] i_weight_t,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [31:0] o_surface_x,
    output logic signed [31:0] o_surface_y,
    output logic signed [31:0] o_surface_z
);
    import bte_pkg::*;
`include "bezier_triangle_eval_macros.svh"

    localparam int MAX_DEGREE = MAX_DEGREE_DEF;
    localparam int DW = $clog2(MAX_DEGREE + 2);

    logic [95:0] r_ctl_mem [NET_DEPTH];
    logic [95:0] r_wrk_mem [NET_DEPTH];
    logic [95:0] r_ctl_rd, r_wrk_rd;
    logic [95:0] r_pa, r_pb, r_pc;

    t_state r_state, n_state;
    logic [3:0]  r_deg;
    logic [DW-1:0] r_n, r_k, r_i1, r_i2;
    logic [5:0]  r_cp, r_cp_d;
    logic        r_cp_v;
    logic [3:0]  r_ph;
    logic [15:0] r_wr, r_ws, r_wt;
    logic [31:0] r_res [3];
    logic        r_ov;

    logic        w_acc_in, w_acc_out;
    logic        w_fin;
    logic [DW-1:0] w_lvl;
    logic [7:0]  w_base_k, w_base_l, w_a, w_b, w_c, w_dst, w_size;
    logic [5:0]  w_rd_addr;
    logic [1:0]  w_j, w_m;
    t_mac_ctl    w_ctl;
    logic [31:0] w_mac;
    logic [DW-1:0] w_ncl;

    assign o_stall   = (r_state != ST_IDLE);
    assign w_acc_in  = i_valid && !o_stall;
    assign w_acc_out = r_ov && !i_stall;
    assign o_valid   = r_ov;
    assign o_surface_x = r_res[0];
    assign o_surface_y = r_res[1];
    assign o_surface_z = r_res[2];

    assign w_ncl = (r_deg > 4'(MAX_DEGREE)) ? DW'(MAX_DEGREE) : DW'(r_deg);
    assign w_lvl = r_k - 1'b1;
    // level 0 holds a single point, so its write-back ends the evaluation
    assign w_fin = (r_state == ST_BLEND) && (r_ph == 4'd10) && (r_k == DW'(1));

    // row base: i1*(k+1) - i1*(i1-1)/2, small multiplies on narrow values
    assign w_base_k = 8'(r_i1 * (r_k + 1'b1)) - 8'((r_i1 * (r_i1 - 1'b1)) >> 1);
    assign w_base_l = 8'(r_i1 * r_k) - 8'((r_i1 * (r_i1 - 1'b1)) >> 1);
    assign w_c   = w_base_k + 8'(r_i2);
    assign w_b   = w_c + 8'd1;
    assign w_a   = w_c + 8'(r_k) + 8'd1 - 8'(r_i1);
    assign w_dst = w_base_l + 8'(r_i2);
    assign w_size = 8'(((r_n + 1'b1) * (r_n + 2'd2)) >> 1);

    always_comb begin
        unique case (r_state)
            ST_RD_A: w_rd_addr = w_a[5:0];
            ST_RD_B: w_rd_addr = w_b[5:0];
            default: w_rd_addr = w_c[5:0];
        endcase
    end

    // phase -> coordinate (w_j) and term (w_m)
    always_comb begin
        priority if (r_ph >= 4'd9) begin
            w_j = 2'd3;
            w_m = 2'(r_ph - 4'd9);
        end else if (r_ph >= 4'd6) begin
            w_j = 2'd2;
            w_m = 2'(r_ph - 4'd6);
        end else if (r_ph >= 4'd3) begin
            w_j = 2'd1;
            w_m = 2'(r_ph - 4'd3);
        end else begin
            w_j = 2'd0;
            w_m = 2'(r_ph);
        end
    end

    always_comb begin
        w_ctl.clr   = (r_state == ST_RD_C) || (w_m == 2'd0);
        w_ctl.start = (r_state == ST_BLEND) && (r_ph < 4'd9);
        unique case (w_m)
            2'd0:    w_ctl.w = r_wr;
            2'd1:    w_ctl.w = r_ws;
            default: w_ctl.w = r_wt;
        endcase
        unique case ({w_m, w_j})
            {2'd0, 2'd0}: w_ctl.a = r_pa[31:0];
            {2'd0, 2'd1}: w_ctl.a = r_pa[63:32];
            {2'd0, 2'd2}: w_ctl.a = r_pa[95:64];
            {2'd1, 2'd0}: w_ctl.a = r_pb[31:0];
            {2'd1, 2'd1}: w_ctl.a = r_pb[63:32];
            {2'd1, 2'd2}: w_ctl.a = r_pb[95:64];
            {2'd2, 2'd0}: w_ctl.a = r_pc[31:0];
            {2'd2, 2'd1}: w_ctl.a = r_pc[63:32];
            {2'd2, 2'd2}: w_ctl.a = r_pc[95:64];
            default:      w_ctl.a = '0;
        endcase
    end

    bte_mac u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl),
        .o_res  (w_mac)
    );

    // memories
    always_ff @(posedge i_clk) begin
        if (w_acc_in && !i_mode && i_point_index < 6'(NET_DEPTH)) begin
            r_ctl_mem[i_point_index] <= {i_coord_z, i_coord_y, i_coord_x};
        end
        r_ctl_rd <= r_ctl_mem[r_cp];
        if (r_cp_v) begin
            r_wrk_mem[r_cp_d] <= r_ctl_rd;
        end else if (r_state == ST_BLEND && r_ph == 4'd10) begin
            r_wrk_mem[w_dst[5:0]] <= {r_res[2], r_res[1], r_res[0]};
        end
        r_wrk_rd <= r_wrk_mem[w_rd_addr];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_acc_in && i_mode) n_state = ST_COPY;
            ST_COPY:  if (!r_cp_v && 8'(r_cp) >= w_size)
                          n_state = (r_n == '0) ? ST_RD_C : ST_RD_A;
            ST_RD_A:  n_state = ST_RD_B;
            ST_RD_B:  n_state = ST_RD_C;
            ST_RD_C:  n_state = (r_k == '0) ? ST_OUT : ST_BLEND;
            ST_BLEND: if (r_ph == 4'd10) begin
                if (w_fin) n_state = ST_OUT;
                else n_state = ST_RD_A;
            end
            ST_OUT:   if (r_ov && w_acc_out) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_deg   <= 4'd3;
            r_ov    <= 1'b0;
            r_cp_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_deg <= i_cfg_data;
            if (w_acc_out) r_ov <= 1'b0;
            r_cp_v <= (r_state == ST_COPY) && (8'(r_cp) < w_size);
            if ((r_state == ST_RD_C && r_k == '0) || w_fin) r_ov <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_d <= r_cp;
        unique case (r_state)
            ST_IDLE: begin
                r_wr <= i_weight_r;
                r_ws <= i_weight_s;
                r_wt <= i_weight_t;
                r_n  <= w_ncl;
                r_k  <= w_ncl;
                r_cp <= '0;
                r_i1 <= '0;
                r_i2 <= '0;
                r_ph <= '0;
            end
            ST_COPY: if (8'(r_cp) < w_size) r_cp <= r_cp + 1'b1;
            ST_RD_A: ;
            ST_RD_B: r_pa <= r_wrk_rd;
            ST_RD_C: begin
                r_pb <= r_wrk_rd;
                r_ph <= '0;
            end
            ST_BLEND: begin
                if (r_ph == 4'd0) r_pc <= r_wrk_rd;
                r_ph <= r_ph + 1'b1;
                if (r_ph == 4'd3 || r_ph == 4'd6 || r_ph == 4'd9)
                    r_res[w_j - 2'd1] <= w_mac;
                if (r_ph == 4'd10) begin
                    if (r_i2 < w_lvl - r_i1) begin
                        r_i2 <= r_i2 + 1'b1;
                    end else if (r_i1 < w_lvl) begin
                        r_i1 <= r_i1 + 1'b1;
                        r_i2 <= '0;
                    end else begin
                        r_k  <= w_lvl;
                        r_i1 <= '0;
                        r_i2 <= '0;
                    end
                end
            end
            ST_OUT: ;
            default: ;
        endcase
        if (r_state == ST_RD_C && r_k == '0) begin
            r_res[0] <= r_wrk_rd[31:0];
            r_res[1] <= r_wrk_rd[63:32];
            r_res[2] <= r_wrk_rd[95:64];
        end
    end

    `BTE_ASSERT_IMPL(a_out_only_done, r_ov, r_state == ST_OUT, "result valid outside output state")
    `BTE_ASSERT_NEXT(a_busy_after_eval, w_acc_in && i_mode, o_stall, "evaluate did not start")
    `BTE_ASSERT_IMPL(a_phase_range, r_state == ST_BLEND, r_ph <= 4'd10, "blend phase overrun")
endmodule
`default_nettype wire
